/* rtl/core/epg_pkg.sv */
// ----------------------------------------------------------------------------
// Ellipse phantom package
// Shared widths, constants, the ellipse table and the lane interface types.
// ----------------------------------------------------------------------------
package epg_pkg;

   // Field and register widths
   localparam int ROW_W       = 12;
   localparam int DIM_W       = 13;
   localparam int SPACING_W   = 16;
   localparam int VALUE_W     = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   // Datapath widths
   localparam int OFFS_W  = 28;               // centred offset, units of 1e-4 half-pixel
   localparam int AREA_W  = DIM_W + SPACING_W; // size times spacing
   localparam int PROD_W  = 44;               // offset times spacing
   localparam int DEN_W   = 42;               // axis times size times spacing
   localparam int NUM_W   = 61;               // rotated numerator
   localparam int MAG_W   = 60;               // numerator magnitude
   localparam int REM_W   = 58;               // divider remainder and divisor
   localparam int QUO_W   = 30;               // Q2.28 ratio
   localparam int SQ_W    = 60;               // squared ratio, Q4.56
   localparam int GRAY_W  = 8;

   localparam int TABLE_SIZE    = 10;
   localparam int MAX_DIMENSION = 4096;
   localparam int FRAC_BITS     = 28;
   localparam int DEN_SHIFT     = REM_W - DEN_W;

   // Trig constants, Q1.16
   localparam logic signed [17:0] ONE_Q16   = 18'sd65536;
   localparam logic signed [17:0] COS18_Q16 = 18'sd62329;
   localparam logic signed [17:0] SIN18_Q16 = 18'sd20252;

   // 1 + 1e-6 in Q4.56
   localparam logic [SQ_W:0] INSIDE_LIMIT = (61'd1 << 56) + 61'd72057594038;

   // Output scaling: tenths to Q4.12 via reciprocal of five
   localparam logic [17:0] RECIP5      = 18'd209716;
   localparam int          RECIP_SHIFT = 20;

   // Stage counts
   localparam int LANE_LATENCY  = 35;
   localparam int SHADE_LATENCY = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMNS   = 8'd0,
      CSR_ROWS      = 8'd1,
      CSR_SPACING_H = 8'd2,
      CSR_SPACING_V = 8'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ROT_NONE,
      ROT_POS,
      ROT_NEG
   } rot_type;

   typedef struct packed {
      logic [13:0]              ax;
      logic [13:0]              ay;
      logic signed [15:0]       cx;
      logic signed [15:0]       cy;
      rot_type                  rot;
      logic signed [GRAY_W-1:0] gray;
   } shape_type;

   // Pixel position plus the configuration snapshot taken with it
   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [ROW_W-1:0]     column;
      logic [DIM_W-1:0]     w;
      logic [DIM_W-1:0]     h;
      logic [SPACING_W-1:0] sx;
      logic [SPACING_W-1:0] sy;
   } geom_type;

   // Axes and centres in units of 1e-4, gray in tenths
   function automatic shape_type shape_of(input int idx);
      shape_type s;
      s = '0;
      case (idx)
         0: s = '{14'd6900, 14'd9200,  16'sd0,     16'sd0,     ROT_NONE,  8'sd20};
         1: s = '{14'd6624, 14'd8740,  16'sd0,    -16'sd184,   ROT_NONE, -8'sd10};
         2: s = '{14'd1100, 14'd3100,  16'sd2200,  16'sd0,     ROT_NEG,  -8'sd10};
         3: s = '{14'd1600, 14'd4100, -16'sd1800,  16'sd0,     ROT_POS,  -8'sd10};
         4: s = '{14'd2100, 14'd2500,  16'sd0,     16'sd2500,  ROT_NONE,  8'sd5};
         5: s = '{14'd460,  14'd460,   16'sd0,     16'sd1000,  ROT_NONE,  8'sd1};
         6: s = '{14'd460,  14'd460,   16'sd0,    -16'sd1000,  ROT_NONE,  8'sd1};
         7: s = '{14'd460,  14'd230,  -16'sd800,  -16'sd3050,  ROT_NONE,  8'sd2};
         8: s = '{14'd230,  14'd230,   16'sd0,    -16'sd3050,  ROT_NONE,  8'sd3};
         9: s = '{14'd230,  14'd460,   16'sd600,  -16'sd3050,  ROT_NONE, -8'sd2};
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

/* rtl/core/epg_if.sv */
// ----------------------------------------------------------------------------
// Ellipse phantom channels
// Valid/ready channels for pixel requests and pixel responses.
// ----------------------------------------------------------------------------
interface epg_req_if;
   logic                          valid;
   logic                          ready;
   logic [epg_pkg::ROW_W-1:0]     pixel_row;
   logic [epg_pkg::ROW_W-1:0]     pixel_column;

   modport source (output valid, output pixel_row, output pixel_column, input ready);
   modport sink   (input valid, input pixel_row, input pixel_column, output ready);
endinterface

interface epg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [epg_pkg::VALUE_W-1:0]  gray_value;

   modport source (output valid, output gray_value, input ready);
   modport sink   (input valid, input gray_value, output ready);
endinterface

/* rtl/core/ellipse_phantom_pixel_generator.sv */
// ----------------------------------------------------------------------------
// Ellipse phantom pixel generator
// Computes the summed gray value of a ten-ellipse head phantom per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one word per pixel (row, column); rsp_bus returns one
//   word per pixel with the signed Q4.12 gray value, in request order.
//   The csr port writes image width, height and the two Q4.12 spacings;
//   write it only while no pixel is in flight.
// Timing:
//   One pixel per cycle is accepted while the output buffer has room.
//   Depth is set by the per-lane restoring dividers, which resolve the two
//   integer bits together, then one fraction bit per stage over 28 bits.
// Reset:
//   Synchronous, active high. Empties the pipeline and the output buffer and
//   loads a 256 x 256 image with unit spacing.
// Backpressure:
//   A two-word output buffer holds results; while it is full the whole
//   pipeline freezes with its words in place and req_bus.ready drops.
// ----------------------------------------------------------------------------
module ellipse_phantom_pixel_generator #(
   parameter int ELLIPSE_COUNT = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   epg_req_if.sink                              req_bus,
   epg_rsp_if.source                            rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [epg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [epg_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import epg_pkg::*;

   localparam int LANES      = (ELLIPSE_COUNT < TABLE_SIZE) ? ELLIPSE_COUNT : TABLE_SIZE;
   localparam int PIPE_DEPTH = 1 + LANE_LATENCY + SHADE_LATENCY;

   logic [DIM_W-1:0]     columns_ff, rows_ff;
   logic [SPACING_W-1:0] spacing_h_ff, spacing_v_ff;
   logic [DIM_W-1:0]     w_clamp, h_clamp;

   logic                 enable;
   logic [PIPE_DEPTH-1:0] valid_ff;
   geom_type             geom_ff;
   logic [AREA_W-1:0]    ws_ff, hs_ff;
   logic [LANES-1:0]     hit;
   logic signed [VALUE_W-1:0] value;

   logic signed [VALUE_W-1:0] buf_ff [2];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           count_ff;
   logic                 push, pop;

   // Configuration writes; unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= DIM_W'(256);
         rows_ff      <= DIM_W'(256);
         spacing_h_ff <= SPACING_W'(4096);
         spacing_v_ff <= SPACING_W'(4096);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLUMNS:   columns_ff   <= csr_write_data[DIM_W-1:0];
            CSR_ROWS:      rows_ff      <= csr_write_data[DIM_W-1:0];
            CSR_SPACING_H: spacing_h_ff <= csr_write_data[SPACING_W-1:0];
            CSR_SPACING_V: spacing_v_ff <= csr_write_data[SPACING_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the image size
   assign w_clamp = (int'(columns_ff) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : columns_ff;
   assign h_clamp = (int'(rows_ff) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : rows_ff;

   // Advance the pipeline whenever the output buffer has room
   assign enable        = (count_ff != 2'd2);
   assign req_bus.ready = enable && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_bus.valid};
      end
   end

   // Capture the pixel with a configuration snapshot, then size times spacing
   always_ff @(posedge clock) begin
      if (enable) begin
         geom_ff <= '{row:    req_bus.pixel_row,
                      column: req_bus.pixel_column,
                      w:      w_clamp,
                      h:      h_clamp,
                      sx:     spacing_h_ff,
                      sy:     spacing_v_ff};
         ws_ff   <= AREA_W'(geom_ff.w) * AREA_W'(geom_ff.sx);
         hs_ff   <= AREA_W'(geom_ff.h) * AREA_W'(geom_ff.sy);
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      epg_lane #(
         .IDX (k)
      ) u_lane (
         .clock  (clock),
         .enable (enable),
         .geom   (geom_ff),
         .ws     (ws_ff),
         .hs     (hs_ff),
         .hit    (hit[k])
      );
   end

   epg_shade #(
      .LANE_COUNT (LANES)
   ) u_shade (
      .clock      (clock),
      .enable     (enable),
      .hit        (hit),
      .gray_value (value)
   );

   // Two-word output buffer
   assign push = enable && valid_ff[PIPE_DEPTH-1];
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   assign rsp_bus.valid      = (count_ff != '0);
   assign rsp_bus.gray_value = buf_ff[rd_ptr_ff];

endmodule

/* rtl/core/epg_div.sv */
// ----------------------------------------------------------------------------
// Pipelined ratio divider
// Q2.28 magnitude of num / (den * 2^16), one fraction bit per stage.
// ----------------------------------------------------------------------------
module epg_div (
   input  logic                               clock,
   input  logic                               enable,
   input  logic signed [epg_pkg::NUM_W-1:0]   num,
   input  logic [epg_pkg::DEN_W-1:0]          den,
   output logic [epg_pkg::QUO_W-1:0]          quo,
   output logic                               ok
);
   import epg_pkg::*;

   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [REM_W-1:0] dsr_ff;
   logic [REM_W:0]   two_den;

   logic [REM_W-1:0] rem_ff [FRAC_BITS+1];
   logic [REM_W-1:0] den_ff [FRAC_BITS+1];
   logic [QUO_W-1:0] q_ff   [FRAC_BITS+1];
   logic             ok_ff  [FRAC_BITS+1];

   // Take the magnitude and scale the divisor
   assign mag_in = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff <= mag_in;
         dsr_ff <= {den, {DEN_SHIFT{1'b0}}};
      end
   end

   // Integer part and far-outside check
   assign two_den = {dsr_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff[0] <= dsr_ff;
         ok_ff[0]  <= (dsr_ff != '0) && (mag_ff <= MAG_W'(two_den));
         if (mag_ff >= MAG_W'(two_den)) begin
            q_ff[0]   <= QUO_W'(2);
            rem_ff[0] <= REM_W'(mag_ff - MAG_W'(two_den));
         end else if (mag_ff >= MAG_W'(dsr_ff)) begin
            q_ff[0]   <= QUO_W'(1);
            rem_ff[0] <= REM_W'(mag_ff - MAG_W'(dsr_ff));
         end else begin
            q_ff[0]   <= '0;
            rem_ff[0] <= REM_W'(mag_ff);
         end
      end
   end

   // Restoring steps, one fraction bit each
   for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
      logic [REM_W:0] shifted;
      assign shifted = {rem_ff[k-1], 1'b0};

      always_ff @(posedge clock) begin
         if (enable) begin
            den_ff[k] <= den_ff[k-1];
            ok_ff[k]  <= ok_ff[k-1];
            if (shifted >= {1'b0, den_ff[k-1]}) begin
               rem_ff[k] <= REM_W'(shifted - {1'b0, den_ff[k-1]});
               q_ff[k]   <= {q_ff[k-1][QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[k] <= REM_W'(shifted);
               q_ff[k]   <= {q_ff[k-1][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   assign quo = q_ff[FRAC_BITS];
   assign ok  = ok_ff[FRAC_BITS];

endmodule

/* rtl/core/epg_lane.sv */
// ----------------------------------------------------------------------------
// Ellipse lane
// Tests one pixel against one fixed ellipse: offset, scale, rotate, divide,
// square and compare.
// ----------------------------------------------------------------------------
module epg_lane #(
   parameter int IDX = 0
) (
   input  logic                            clock,
   input  logic                            enable,
   input  epg_pkg::geom_type               geom,
   input  logic [epg_pkg::AREA_W-1:0]      ws,
   input  logic [epg_pkg::AREA_W-1:0]      hs,
   output logic                            hit
);
   import epg_pkg::*;

   localparam shape_type SHAPE = shape_of(IDX);
   localparam logic signed [17:0] COS_Q = (SHAPE.rot == ROT_NONE) ? ONE_Q16 : COS18_Q16;
   localparam logic signed [17:0] SIN_Q = (SHAPE.rot == ROT_NONE) ? 18'sd0 :
                                          (SHAPE.rot == ROT_POS) ? SIN18_Q16 : -SIN18_Q16;
   localparam logic signed [14:0] SCALE = 15'sd10000;

   logic signed [14:0]       tx, ty;
   logic signed [OFFS_W-1:0] p_ff, q_ff, p_in, q_in;
   logic [SPACING_W-1:0]     sx_ff, sy_ff;
   logic signed [PROD_W-1:0] px_ff, qy_ff;
   logic [DEN_W-1:0]         d1_ff, d2_ff, d1_l3_ff, d2_l3_ff;
   logic signed [NUM_W-1:0]  n1_ff, n2_ff;
   logic [QUO_W-1:0]         quo1, quo2;
   logic                     ok1, ok2;
   logic [SQ_W-1:0]          sq1_ff, sq2_ff;
   logic                     sq_ok_ff;
   logic                     inside_ff;

   // Centred offsets in units of 1e-4 half-pixel
   assign tx = $signed({2'b00, geom.column, 1'b0}) - $signed({2'b00, geom.w});
   assign ty = $signed({2'b00, geom.h}) - $signed({2'b00, geom.row, 1'b0});
   assign p_in = OFFS_W'(tx) * OFFS_W'(SCALE) - OFFS_W'(SHAPE.cx) * OFFS_W'(geom.w);
   assign q_in = OFFS_W'(ty) * OFFS_W'(SCALE) - OFFS_W'(SHAPE.cy) * OFFS_W'(geom.h);

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff  <= p_in;
         q_ff  <= q_in;
         sx_ff <= geom.sx;
         sy_ff <= geom.sy;
      end
   end

   // Apply spacing, form the scaled semi-axes
   always_ff @(posedge clock) begin
      if (enable) begin
         px_ff <= PROD_W'(p_ff) * PROD_W'(sx_ff);
         qy_ff <= PROD_W'(q_ff) * PROD_W'(sy_ff);
         d1_ff <= DEN_W'(SHAPE.ax) * DEN_W'(ws);
         d2_ff <= DEN_W'(SHAPE.ay) * DEN_W'(hs);
      end
   end

   // Rotate into the ellipse frame
   always_ff @(posedge clock) begin
      if (enable) begin
         n1_ff    <= NUM_W'(px_ff) * NUM_W'(COS_Q) + NUM_W'(qy_ff) * NUM_W'(SIN_Q);
         n2_ff    <= NUM_W'(qy_ff) * NUM_W'(COS_Q) - NUM_W'(px_ff) * NUM_W'(SIN_Q);
         d1_l3_ff <= d1_ff;
         d2_l3_ff <= d2_ff;
      end
   end

   epg_div u_div_major (
      .clock  (clock),
      .enable (enable),
      .num    (n1_ff),
      .den    (d1_l3_ff),
      .quo    (quo1),
      .ok     (ok1)
   );

   epg_div u_div_minor (
      .clock  (clock),
      .enable (enable),
      .num    (n2_ff),
      .den    (d2_l3_ff),
      .quo    (quo2),
      .ok     (ok2)
   );

   // Square both ratios, then compare against the tolerance
   always_ff @(posedge clock) begin
      if (enable) begin
         sq1_ff    <= SQ_W'(quo1) * SQ_W'(quo1);
         sq2_ff    <= SQ_W'(quo2) * SQ_W'(quo2);
         sq_ok_ff  <= ok1 && ok2;
         inside_ff <= sq_ok_ff && (({1'b0, sq1_ff} + {1'b0, sq2_ff}) <= INSIDE_LIMIT);
      end
   end

   assign hit = inside_ff;

endmodule

/* rtl/core/epg_shade.sv */
// ----------------------------------------------------------------------------
// Gray value accumulator
// Sums the gray values of the hit ellipses and converts tenths to Q4.12.
// ----------------------------------------------------------------------------
module epg_shade #(
   parameter int LANE_COUNT = 10
) (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic [LANE_COUNT-1:0]                hit,
   output logic signed [epg_pkg::VALUE_W-1:0]   gray_value
);
   import epg_pkg::*;

   localparam int PRODUCT_W = 36;

   logic signed [GRAY_W-1:0] total_in, total_ff;
   logic [GRAY_W-1:0]        mag;
   logic [17:0]              numer;
   logic [PRODUCT_W-1:0]     prod_ff;
   logic                     neg_ff;
   logic [VALUE_W-1:0]       quot;
   logic signed [VALUE_W-1:0] value_ff;

   // Add up the gray values of every hit
   always_comb begin
      total_in = '0;
      for (int k = 0; k < LANE_COUNT; k++) begin
         if (hit[k]) begin
            total_in = total_in + shape_of(k).gray;
         end
      end
   end

   // Magnitude times 2048/5, rounded
   assign mag   = total_ff[GRAY_W-1] ? GRAY_W'(-total_ff) : GRAY_W'(total_ff);
   assign numer = {mag[6:0], 11'b0} + 18'd2;
   assign quot  = prod_ff[RECIP_SHIFT +: VALUE_W];

   always_ff @(posedge clock) begin
      if (enable) begin
         total_ff <= total_in;
         prod_ff  <= PRODUCT_W'(numer) * PRODUCT_W'(RECIP5);
         neg_ff   <= total_ff[GRAY_W-1];
         value_ff <= neg_ff ? -$signed(quot) : $signed(quot);
      end
   end

   assign gray_value = value_ff;

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Ellipse phantom pixel generator testbench
// Drives pixel words through the request channel under several image sizes
// and spacings. A local model of the ten-ellipse phantom predicts each gray
// value, and the monitor checks every response word against it in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import epg_pkg::*;

   localparam int  SHAPES         = 10;
   localparam int  PHASES         = 9;
   localparam int  ITEMS_PER_PASS = 170;
   localparam int  DRAIN_CYCLES   = 50;
   localparam int  WATCHDOG_LIMIT = 3000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 8'd7;
   localparam longint unsigned BOUND_Q56 = (64'd1 << 56) + 64'd72057594038;

   // Ellipse table: axes and centres in units of 1e-4, gray in tenths
   localparam int      AX_TAB[SHAPES]   = '{6900, 6624, 1100, 1600, 2100,
                                            460, 460, 460, 230, 230};
   localparam int      AY_TAB[SHAPES]   = '{9200, 8740, 3100, 4100, 2500,
                                            460, 460, 230, 230, 460};
   localparam int      CX_TAB[SHAPES]   = '{0, 0, 2200, -1800, 0,
                                            0, 0, -800, 0, 600};
   localparam int      CY_TAB[SHAPES]   = '{0, -184, 0, 0, 2500,
                                            1000, -1000, -3050, -3050, -3050};
   localparam rot_type ROT_TAB[SHAPES]  = '{ROT_NONE, ROT_NONE, ROT_NEG, ROT_POS,
                                            ROT_NONE, ROT_NONE, ROT_NONE, ROT_NONE,
                                            ROT_NONE, ROT_NONE};
   localparam int      GRAY_TAB[SHAPES] = '{20, -10, -10, -10, 5, 1, 1, 2, 3, -2};

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] column;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   epg_req_if req_bus ();
   epg_rsp_if rsp_bus ();

   ellipse_phantom_pixel_generator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Shadow copy of the configuration registers
   int unsigned cols_cfg  = 256;
   int unsigned rows_cfg  = 256;
   int unsigned sx_cfg    = 4096;
   int unsigned sy_cfg    = 4096;

   pixel_type                pending_pixels[$];
   logic signed [VALUE_W-1:0] expected_values[$];
   int  error_count  = 0;
   bit  quiet_phase  = 1'b0;
   int  send_gap     = 0;
   int  stall_left   = 0;
   int  idle_cycles  = 0;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_phase || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Q2.28 magnitude of num/den; zero when the ellipse cannot contain the point
   function automatic bit axis_ratio(input longint num, input longint unsigned den,
                                     output longint unsigned ratio);
      longint unsigned mag, quo, rem;
      ratio = 0;
      if (den == 0) return 1'b0;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      if (mag > 2 * den) return 1'b0;
      quo = mag / den;
      rem = mag % den;
      for (int k = 0; k < 28; k++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 1;
         end
      end
      ratio = quo;
      return 1'b1;
   endfunction

   function automatic logic signed [VALUE_W-1:0] phantom_value(input pixel_type px);
      longint w, h, sx, sy, c, s, dx, dy, n1, n2, total, mag;
      longint unsigned d1, d2, r1, r2;
      w  = (cols_cfg > MAX_DIMENSION) ? MAX_DIMENSION : cols_cfg;
      h  = (rows_cfg > MAX_DIMENSION) ? MAX_DIMENSION : rows_cfg;
      sx = sx_cfg;
      sy = sy_cfg;
      total = 0;
      for (int k = 0; k < SHAPES; k++) begin
         c = (ROT_TAB[k] == ROT_NONE) ? 65536 : 62329;
         s = (ROT_TAB[k] == ROT_NONE) ? 0 : ((ROT_TAB[k] == ROT_POS) ? 20252 : -20252);
         dx = (10000 * (2 * longint'(px.column) - w) - CX_TAB[k] * w) * sx;
         dy = (10000 * (h - 2 * longint'(px.row)) - CY_TAB[k] * h) * sy;
         n1 = dx * c + dy * s;
         n2 = dy * c - dx * s;
         d1 = longint'(AX_TAB[k]) * w * sx * 65536;
         d2 = longint'(AY_TAB[k]) * h * sy * 65536;
         if (!axis_ratio(n1, d1, r1)) continue;
         if (!axis_ratio(n2, d2, r2)) continue;
         if (r1 * r1 + r2 * r2 <= BOUND_Q56) total += GRAY_TAB[k];
      end
      mag = (total < 0) ? -total : total;
      mag = (mag * 2048 + 2) / 5;
      return (total < 0) ? VALUE_W'(-mag) : VALUE_W'(mag);
   endfunction

   // Driver: present the next pixel word, with random gaps between words
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.pixel_row    <= '0;
         req_bus.pixel_column <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_values.push_back(
               phantom_value('{req_bus.pixel_row, req_bus.pixel_column}));
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap      <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
               pixel_type px;
               px = pending_pixels.pop_front();
               req_bus.pixel_row    <= px.row;
               req_bus.pixel_column <= px.column;
               req_bus.valid        <= 1'b1;
               send_gap             <= pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall the response side at random and check each word
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_values.size() == 0) begin
               $error("gray_value: unexpected word %0d", rsp_bus.gray_value);
               error_count++;
            end else begin
               logic signed [VALUE_W-1:0] want;
               want = expected_values.pop_front();
               if (rsp_bus.gray_value !== want) begin
                  $error("gray_value: expected %0d, actual %0d", want,
                         rsp_bus.gray_value);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left    <= pick_gap();
         end
      end
   end

   // Watchdog: count cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** ellipse_phantom_pixel_generator: FAILED **");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_COLUMNS:   cols_cfg = data & 16'h1FFF;
         CSR_ROWS:      rows_cfg = data & 16'h1FFF;
         CSR_SPACING_H: sx_cfg   = data;
         CSR_SPACING_V: sy_cfg   = data;
         default: ;
      endcase
   endtask

   task automatic apply_config(input int w, input int h, input int sx, input int sy);
      write_csr(CSR_COLUMNS, CSR_DATA_W'(w));
      write_csr(CSR_ROWS, CSR_DATA_W'(h));
      write_csr(CSR_SPACING_H, CSR_DATA_W'(sx));
      write_csr(CSR_SPACING_V, CSR_DATA_W'(sy));
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Hold until every word is out, then let the pipeline drain; sample
   // between edges so the handshake updates have settled
   task automatic wait_idle();
      while (pending_pixels.size() > 0 || req_bus.valid || expected_values.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_pixel(input int row, input int column);
      pending_pixels.push_back('{ROW_W'(row), ROW_W'(column)});
   endtask

   // Random pixels: mostly inside the image, some anywhere in the field range
   task automatic add_random_pixels(input int count);
      int wlim, hlim;
      wlim = (cols_cfg > MAX_DIMENSION) ? MAX_DIMENSION : ((cols_cfg == 0) ? 1 : cols_cfg);
      hlim = (rows_cfg > MAX_DIMENSION) ? MAX_DIMENSION : ((rows_cfg == 0) ? 1 : rows_cfg);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0)
            add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
         else
            add_pixel($urandom_range(0, hlim - 1), $urandom_range(0, wlim - 1));
      end
   endtask

   initial begin
      int w, h, sx, sy;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: corners, centre and each ellipse centre at reset config
      quiet_phase = 1'b1;
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(0, 4095);
      add_pixel(4095, 0);
      add_pixel(128, 128);
      add_pixel(255, 255);
      for (int k = 0; k < SHAPES; k++)
         add_pixel((256 - CY_TAB[k] * 256 / 10000) / 2, (256 + CX_TAB[k] * 256 / 10000) / 2);
      wait_idle();
      quiet_phase = 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin w = 4096; h = 4096; sx = 65535; sy = 65535; end
            1: begin w = 1;    h = 1;    sx = 1;     sy = 1;     end
            2: begin w = 8191; h = 5000; sx = 4096;  sy = 65535; end
            3: begin w = 0;    h = 256;  sx = 4096;  sy = 4096;  end
            4: begin w = 128;  h = 300;  sx = 0;     sy = 4096;  end
            5: begin w = 256;  h = 256;  sx = 4096;  sy = 4096;  end
            default: begin
               w  = $urandom_range(1, 8191);
               h  = $urandom_range(1, 8191);
               sx = $urandom_range(1, 65535);
               sy = $urandom_range(1, 65535);
            end
         endcase
         quiet_phase = (p == 5);
         apply_config(w, h, sx, sy);
         add_random_pixels(ITEMS_PER_PASS / 2);
         // Pause the sender until everything so far has come back
         wait_idle();
         add_random_pixels(ITEMS_PER_PASS - ITEMS_PER_PASS / 2);
         wait_idle();
      end

      if (error_count == 0)
         $display("** ellipse_phantom_pixel_generator: PASSED **");
      else
         $display("** ellipse_phantom_pixel_generator: FAILED **");
      $finish;
   end

endmodule

/* ellipse_phantom_pixel_generator.f */
rtl/core/epg_pkg.sv
rtl/core/epg_if.sv
rtl/core/epg_div.sv
rtl/core/epg_lane.sv
rtl/core/epg_shade.sv
rtl/core/ellipse_phantom_pixel_generator.sv
tb/sv/testbench.sv
